### hw/rtl/rau_pkg.sv
package rau_pkg;

  // result word size; products and the gcd datapath are twice as wide
  localparam int WORD_BITS = 32;
  localparam int WIDE_BITS = 64;
  localparam int MUL_BITS  = 33;
  localparam int CNT_BITS  = $clog2(WIDE_BITS);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // one input beat, unpacked
  typedef struct packed {
    op_t         op;
    logic [31:0] a_num;
    logic [30:0] a_den;
    logic [31:0] b_num;
    logic [30:0] b_den;
  } in_t;

  // one result beat
  typedef struct packed {
    logic [31:0] res_num;
    logic [31:0] res_den;
    logic        div_zero;
    logic        overflow;
  } res_t;

endpackage

### hw/rtl/rau_mul.sv
module rau_mul (
  input  logic                               clk,
  input  logic signed [rau_pkg::MUL_BITS-1:0] a,
  input  logic signed [rau_pkg::MUL_BITS-1:0] b,
  output logic        [rau_pkg::WIDE_BITS-1:0] p
);

  logic signed [2*rau_pkg::MUL_BITS-1:0] prod;

  // signed product, registered; the product never exceeds 2^62 in magnitude
  assign prod = a * b;

  always_ff @(posedge clk) begin
    p <= prod[rau_pkg::WIDE_BITS-1:0];
  end

endmodule

### hw/rtl/rau_addsub.sv
module rau_addsub (
  input  logic [rau_pkg::WIDE_BITS-1:0] a,
  input  logic [rau_pkg::WIDE_BITS-1:0] b,
  input  logic                          sub,
  output logic [rau_pkg::WIDE_BITS-1:0] sum,
  output logic                          cout
);

  logic [rau_pkg::WIDE_BITS-1:0] b_eff;

  // a + b or a - b; on subtract cout high means no borrow (a >= b)
  assign b_eff = sub ? ~b : b;
  assign {cout, sum} = {1'b0, a} + {1'b0, b_eff} + {{rau_pkg::WIDE_BITS{1'b0}}, sub};

endmodule

### hw/rtl/rau_core.sv
module rau_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rau_pkg::in_t   in_item,
  input  logic           slot_free,
  output logic           idle,
  output logic           res_valid,
  output rau_pkg::res_t  res
);

  localparam int W  = rau_pkg::WORD_BITS;
  localparam int WB = rau_pkg::WIDE_BITS;
  localparam int MB = rau_pkg::MUL_BITS;
  localparam int CB = rau_pkg::CNT_BITS;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_MUL1 = 12'b0000_0000_0010,
    ST_MUL2 = 12'b0000_0000_0100,
    ST_MUL3 = 12'b0000_0000_1000,
    ST_SUM  = 12'b0000_0001_0000,
    ST_ABSN = 12'b0000_0010_0000,
    ST_ABSD = 12'b0000_0100_0000,
    ST_GCD  = 12'b0000_1000_0000,
    ST_DIVN = 12'b0001_0000_0000,
    ST_DIVD = 12'b0010_0000_0000,
    ST_FIN  = 12'b0100_0000_0000,
    ST_SPARE = 12'b1000_0000_0000
  } state_t;

  state_t        state, state_next;
  rau_pkg::in_t  item;
  logic [WB-1:0] x, y, n0, d0;
  logic [CB-1:0] cnt;
  logic          neg, zero_res, dz;

  logic signed [MB-1:0] mul_a, mul_b;
  logic [WB-1:0]        prod;
  logic [WB-1:0]        au_a, au_b, au_sum;
  logic                 au_sub, au_cout;

  logic signed [MB-1:0] an_s, bn_s, ad_s, bd_s;
  logic [WB-1:0]        d_abs;
  logic [WB-1:0]        rem_n, rem_d;
  logic [W-1:0]         n_low;
  logic signed [W-1:0]  v_low;
  logic                 ovf;

  rau_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  rau_addsub u_au (
    .a    (au_a),
    .b    (au_b),
    .sub  (au_sub),
    .sum  (au_sum),
    .cout (au_cout)
  );

  assign an_s = MB'(signed'(item.a_num));
  assign bn_s = MB'(signed'(item.b_num));
  assign ad_s = signed'({2'b00, item.a_den});
  assign bd_s = signed'({2'b00, item.b_den});

  // shifted remainders for the two restoring divisions
  assign rem_n = {y[WB-2:0], n0[WB-1]};
  assign rem_d = {y[WB-2:0], d0[WB-1]};

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL1: begin
        mul_a = an_s;
        mul_b = (item.op == rau_pkg::OP_MUL) ? bn_s : bd_s;
      end
      ST_MUL2: begin
        mul_a = bn_s;
        mul_b = ad_s;
      end
      ST_MUL3: begin
        mul_a = ad_s;
        mul_b = (item.op == rau_pkg::OP_DIV) ? bn_s : bd_s;
      end
      default: begin
      end
    endcase
  end

  // shared add/subtract unit operand select
  always_comb begin
    au_a   = '0;
    au_b   = '0;
    au_sub = 1'b1;
    case (state)
      ST_SUM: begin
        au_a   = x;
        au_b   = (item.op inside {rau_pkg::OP_ADD, rau_pkg::OP_SUB}) ? y : '0;
        au_sub = (item.op == rau_pkg::OP_SUB);
      end
      ST_ABSN: au_b = x;
      ST_ABSD: au_b = d0;
      ST_GCD: begin
        au_a = x;
        au_b = y;
      end
      ST_DIVN: begin
        au_a = rem_n;
        au_b = x;
      end
      ST_DIVD: begin
        au_a = rem_d;
        au_b = x;
      end
      default: begin
      end
    endcase
  end

  assign d_abs = d0[WB-1] ? au_sum : d0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_SUM;
      ST_SUM:  state_next = ST_ABSN;
      ST_ABSN: begin
        if (item.op == rau_pkg::OP_DIV && d0 == '0) state_next = ST_FIN;
        else state_next = ST_ABSD;
      end
      ST_ABSD: state_next = (x == '0) ? ST_FIN : ST_GCD;
      ST_GCD: begin
        if (x[0] && y[0] && au_sum == '0) state_next = ST_DIVN;
      end
      ST_DIVN: if (cnt == CB'(WB-1)) state_next = ST_DIVD;
      ST_DIVD: if (cnt == CB'(WB-1)) state_next = ST_FIN;
      ST_FIN:  if (slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          item     <= in_item;
          zero_res <= 1'b0;
          dz       <= 1'b0;
        end
      end
      ST_MUL2: x <= prod;
      ST_MUL3: y <= prod;
      ST_SUM: begin
        d0 <= prod;
        x  <= au_sum;
      end
      ST_ABSN: begin
        neg <= x[WB-1];
        x   <= x[WB-1] ? au_sum : x;
        if (item.op == rau_pkg::OP_DIV && d0 == '0) begin
          dz       <= 1'b1;
          zero_res <= 1'b1;
        end
      end
      ST_ABSD: begin
        neg <= neg ^ d0[WB-1];
        n0  <= x;
        // a zero denominator outside divide counts as one
        y   <= (d_abs == '0) ? WB'(1) : d_abs;
        d0  <= (d_abs == '0) ? WB'(1) : d_abs;
        if (x == '0) zero_res <= 1'b1;
      end
      ST_GCD: begin
        // binary gcd; common factors of two leave the originals as well
        if (!x[0] && !y[0]) begin
          x  <= x >> 1;
          y  <= y >> 1;
          n0 <= n0 >> 1;
          d0 <= d0 >> 1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (au_sum == '0) begin
          y   <= '0;
          cnt <= '0;
        end else if (!au_cout) begin
          x <= y;
          y <= x;
        end else begin
          x <= au_sum;
        end
      end
      ST_DIVN: begin
        // restoring division, quotient shifts into n0; remainder clears at the end
        y   <= (cnt == CB'(WB-1)) ? '0 : (au_cout ? au_sum : rem_n);
        n0  <= {n0[WB-2:0], au_cout};
        cnt <= cnt + CB'(1);
      end
      ST_DIVD: begin
        y   <= au_cout ? au_sum : rem_d;
        d0  <= {d0[WB-2:0], au_cout};
        cnt <= cnt + CB'(1);
      end
      default: begin
      end
    endcase
  end

  // range check and low-word packing of the reduced result
  assign n_low = n0[W-1:0];
  assign v_low = neg ? signed'(W'(0) - n_low) : signed'(n_low);

  always_comb begin
    if (neg) ovf = (|n0[WB-1:W]) || (n0[W-1] && (|n0[W-2:0]));
    else     ovf = |n0[WB-1:W-1];
    if (|d0[WB-1:W-1]) ovf = 1'b1;
  end

  always_comb begin
    if (zero_res) begin
      res.res_num  = '0;
      res.res_den  = 32'd1;
      res.overflow = 1'b0;
    end else begin
      res.res_num  = 32'(v_low);
      res.res_den  = 32'(d0[W-1:0]);
      res.overflow = ovf;
    end
    res.div_zero = dz;
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_FIN) && slot_free;

endmodule

### hw/rtl/rational_arith_unit.sv
// rational_arith_unit: exact add, subtract, multiply or divide of two
// fractions, result reduced by its gcd.
// input channel s_*: one beat carries the op in s_tuser and both fractions in
// s_tdata; s_tready is high only while the sequencer is idle.
// output channel m_*: one beat per input beat, reduced numerator and
// denominator in m_tdata, divide-by-zero and overflow flags in m_tuser.
// steps: the multiplier steps, the sum and sign steps, then binary gcd steps
// on the shared 64-bit add/subtract unit (one shift, subtract or swap each),
// then two restoring divisions on that same unit and a final step to pack.
// zero and divide-by-zero results skip the gcd and divisions.
// a finished result sits in the output register; while the receiver stalls,
// the next item can be taken and worked on, and it waits in its last step
// until the output register is free.
// reset (rst, synchronous) returns the sequencer to idle and empties the
// output register.
module rational_arith_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // a_num[31:0], a_den[62:32], b_num[94:63], b_den[125:95], zero pad
  input  logic [1:0]   s_tuser,  // op[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,  // res_num[31:0], res_den[63:32]
  output logic [1:0]   m_tuser   // div_zero[0], overflow[1]
);

  rau_pkg::in_t  in_item;
  rau_pkg::res_t res;
  logic          idle, res_valid, slot_free;

  // unpack the input beat
  assign in_item.op    = rau_pkg::op_t'(s_tuser);
  assign in_item.a_num = s_tdata[31:0];
  assign in_item.a_den = s_tdata[62:32];
  assign in_item.b_num = s_tdata[94:63];
  assign in_item.b_den = s_tdata[125:95];

  assign s_tready  = idle;
  assign slot_free = !m_tvalid || m_tready;

  rau_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (s_tvalid),
    .in_item   (in_item),
    .slot_free (slot_free),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {res.res_den, res.res_num};
      m_tuser <= {res.overflow, res.div_zero};
    end
  end

endmodule

### hw/rtl/rau_checker.sv
module rau_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [127:0] s_tdata,
  input logic [1:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [63:0]  m_tdata,
  input logic [1:0]   m_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // one item at a time: ready drops after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in flight");

  // divide by zero gives 0/1 without overflow
  a_div_zero_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == {32'd1, 32'd0} && !m_tuser[1])
    else $error("divide by zero result is not 0/1");

  // an in-range result has a positive denominator below 2^(w-1)
  a_den_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[63:32] != 32'd0 &&
      m_tdata[63:32] < (32'd1 << (rau_pkg::WORD_BITS - 1)))
    else $error("denominator out of range without overflow");

  // the output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result beat valid after reset");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### bench/tb_rational_arith_unit.sv
module tb_rational_arith_unit;

  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam int          TAIL_CYCLES = 600;
  localparam logic [31:0] NUM_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] NUM_MIN     = 32'h8000_0000;
  localparam logic [30:0] DEN_MAX     = 31'h7FFF_FFFF;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;  // a_num[31:0], a_den[62:32], b_num[94:63], b_den[125:95], zero pad
  logic [1:0]   s_tuser;  // op[1:0]
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;  // res_num[31:0], res_den[63:32]
  logic [1:0]   m_tuser;  // div_zero[0], overflow[1]

  rau_pkg::res_t pending_results[$];
  rau_pkg::res_t want;
  int            error_count;
  int            burst_left;
  int            long_hold;
  int            cycle_count;

  rational_arith_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // exact fraction arithmetic, reduced by euclid, low bits kept on overflow
  function automatic rau_pkg::res_t exact_rational_result(rau_pkg::in_t it);
    longint          an, ad, bn, bd, n, d;
    longint unsigned nm, dm, x, y, r, g, lim, mask, nv;
    bit              neg, ovf;
    rau_pkg::res_t   e;
    e.res_num  = '0;
    e.res_den  = 32'd1;
    e.div_zero = 1'b0;
    e.overflow = 1'b0;
    an = longint'($signed(it.a_num));
    ad = longint'(it.a_den);
    bn = longint'($signed(it.b_num));
    bd = longint'(it.b_den);
    case (it.op)
      rau_pkg::OP_ADD: begin
        n = an * bd + bn * ad;
        d = ad * bd;
      end
      rau_pkg::OP_SUB: begin
        n = an * bd - bn * ad;
        d = ad * bd;
      end
      rau_pkg::OP_MUL: begin
        n = an * bn;
        d = ad * bd;
      end
      default: begin
        n = an * bd;
        d = ad * bn;
        if (d == 0) begin
          e.div_zero = 1'b1;
          return e;
        end
      end
    endcase
    // a zero denominator outside divide counts as 1
    if (d == 0) d = 1;
    neg = (n < 0);
    nm  = n;
    if (neg) nm = 64'd0 - nm;
    if (d < 0) begin
      dm  = 64'd0 - d;
      neg = !neg;
    end else begin
      dm = d;
    end
    if (nm == 0) return e;
    x = nm;
    y = dm;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    g  = (x == 0) ? 64'd1 : x;
    nm = nm / g;
    dm = dm / g;
    lim = 64'd1 << (rau_pkg::WORD_BITS - 1);
    ovf = neg ? (nm > lim) : (nm > lim - 1);
    if (dm > lim - 1) ovf = 1'b1;
    nv   = neg ? 64'd0 - nm : nm;
    mask = (64'd1 << rau_pkg::WORD_BITS) - 1;
    r    = nv & mask;
    if (r[rau_pkg::WORD_BITS-1]) r = r | ~mask;
    e.res_num  = r[31:0];
    r          = dm & mask;
    e.res_den  = r[31:0];
    e.overflow = ovf;
    return e;
  endfunction

  function automatic rau_pkg::in_t mk_item(rau_pkg::op_t op, logic [31:0] an,
                                           logic [30:0] ad, logic [31:0] bn,
                                           logic [30:0] bd);
    rau_pkg::in_t it;
    it.op    = op;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    return it;
  endfunction

  // numerators: mostly small so that results reduce and fit
  function automatic logic [31:0] rand_num();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 40) - 20;
      4, 5:       return {{16{r[15]}}, r[15:0]};
      6, 7:       return r;
      8: begin
        case ($urandom_range(0, 4))
          0:       return 32'd0;
          1:       return 32'd1;
          2:       return 32'hFFFF_FFFF;
          3:       return NUM_MAX;
          default: return NUM_MIN;
        endcase
      end
      default: begin
        r = $urandom_range(1, 64) * $urandom_range(1, 4096);
        return r[0] ? 32'd0 - r : r;
      end
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 31'($urandom_range(1, 40));
      4, 5:       return 31'($urandom_range(1, 65535));
      6, 7:       return r[30:0];
      8: begin
        case ($urandom_range(0, 2))
          0:       return 31'd0;
          1:       return 31'd1;
          default: return DEN_MAX;
        endcase
      end
      default: begin
        r = $urandom_range(1, 64) * $urandom_range(1, 4096);
        return r[30:0];
      end
    endcase
  endfunction

  // offer one beat, wait for it to be taken, then maybe idle between bursts
  task automatic send_item(input rau_pkg::in_t it);
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {2'b00, it.b_den, it.b_num, it.a_den, it.a_num};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(exact_rational_result(it));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(0, 8);
    end
  endtask

  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic rau_pkg::in_t rand_item();
    rau_pkg::in_t it;
    it = mk_item(rau_pkg::op_t'($urandom_range(0, 3)), rand_num(), rand_den(), rand_num(),
                 rand_den());
    // same operands on both sides: zero difference, unit quotient
    if ($urandom_range(0, 15) == 0) begin
      it.b_num = it.a_num;
      it.b_den = it.a_den;
    end
    return it;
  endfunction

  task automatic test_directed();
    send_item(mk_item(rau_pkg::OP_ADD, 1, 2, 1, 3));
    send_item(mk_item(rau_pkg::OP_SUB, 1, 2, 1, 2));
    send_item(mk_item(rau_pkg::OP_MUL, 2, 3, 3, 4));
    send_item(mk_item(rau_pkg::OP_DIV, 1, 2, 3, 4));
    // divide by a zero fraction, and by a zero product denominator
    send_item(mk_item(rau_pkg::OP_DIV, 5, 7, 0, 1));
    send_item(mk_item(rau_pkg::OP_DIV, 3, 0, 2, 1));
    // zero denominators, outside divide and in a divisor
    send_item(mk_item(rau_pkg::OP_ADD, 1, 0, 1, 3));
    send_item(mk_item(rau_pkg::OP_SUB, 7, 5, 2, 0));
    send_item(mk_item(rau_pkg::OP_MUL, 3, 0, 5, 0));
    send_item(mk_item(rau_pkg::OP_DIV, 3, 4, 5, 0));
    // negative divisor moves its sign to the numerator
    send_item(mk_item(rau_pkg::OP_DIV, 1, 3, -2, 5));
    // wide results
    send_item(mk_item(rau_pkg::OP_MUL, NUM_MAX, 1, NUM_MAX, 1));
    send_item(mk_item(rau_pkg::OP_ADD, NUM_MAX, 1, 1, 1));
    send_item(mk_item(rau_pkg::OP_SUB, NUM_MIN, 1, 1, 1));
    send_item(mk_item(rau_pkg::OP_ADD, NUM_MIN, 1, 0, 1));
    send_item(mk_item(rau_pkg::OP_DIV, NUM_MIN, 1, -1, 1));
    send_item(mk_item(rau_pkg::OP_MUL, 1, DEN_MAX, 1, DEN_MAX));
    send_item(mk_item(rau_pkg::OP_MUL, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX));
    send_item(mk_item(rau_pkg::OP_ADD, NUM_MAX, DEN_MAX, NUM_MIN, 1));
    send_item(mk_item(rau_pkg::OP_DIV, NUM_MIN, 1, NUM_MIN, 1));
    send_item(mk_item(rau_pkg::OP_SUB, 0, DEN_MAX, 0, 1));
    send_item(mk_item(rau_pkg::OP_MUL, -1, 1, -1, 1));
    send_item(mk_item(rau_pkg::OP_DIV, NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX));
    // alternating bit patterns
    send_item(mk_item(rau_pkg::OP_MUL, 32'hAAAA_AAAA, 31'h2AAA_AAAA, 32'h5555_5555,
                      31'h5555_5555));
    send_item(mk_item(rau_pkg::OP_SUB, 32'h5555_5555, 31'h5555_5555, 32'hAAAA_AAAA,
                      31'h2AAA_AAAA));
    pause_until_drained();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_item(rand_item());
    pause_until_drained();
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_long_hold();
    long_hold  = 3000;
    burst_left = 1000;
    for (int i = 0; i < 30; i++) send_item(rand_item());
    burst_left = 0;
    pause_until_drained();
  endtask

  // sender stops until every result is back, then resumes
  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) send_item(rand_item());
    pause_until_drained();
    repeat ($urandom_range(1, 20)) @(posedge clk);
    for (int i = 0; i < 20; i++) send_item(rand_item());
    pause_until_drained();
  endtask

  // receiver ready pattern, with long hold-off on request
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       phase;
    m_tready  = 1'b0;
    mode      = RX_OPEN;
    mode_left = 0;
    phase     = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (long_hold > 0) begin
        m_tready <= 1'b0;
        long_hold--;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 256);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:   m_tready <= ((phase % 8) < 5);
        endcase
      end
    end
  end

  // compare each result beat with the oldest pending one
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: res_num %0d res_den %0d", $signed(m_tdata[31:0]),
               m_tdata[63:32]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[31:0] !== want.res_num) begin
          $error("res_num: expected %0d, got %0d", $signed(want.res_num),
                 $signed(m_tdata[31:0]));
          error_count++;
        end
        if (m_tdata[63:32] !== want.res_den) begin
          $error("res_den: expected %0d, got %0d", want.res_den, m_tdata[63:32]);
          error_count++;
        end
        if (m_tuser[0] !== want.div_zero) begin
          $error("div_zero: expected %0b, got %0b", want.div_zero, m_tuser[0]);
          error_count++;
        end
        if (m_tuser[1] !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, m_tuser[1]);
          error_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // test sequence
  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    error_count = 0;
    burst_left  = 0;
    long_hold   = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(450);
    test_long_hold();
    test_drain_pause();
    test_random(450);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
